// ----- design/vrt_pkg.sv -----
// Package for the voxel ray traversal core: shared constants, result codes,
// and the command and status types between controller and datapath.
// Depends on nothing.
package vrt_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int CELL_BITS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int OUT_CELL_W    = 16;

    localparam logic [1:0] KIND_QUERY  = 2'd0;
    localparam logic [1:0] KIND_HIT    = 2'd1;
    localparam logic [1:0] KIND_MISS   = 2'd2;
    localparam logic [1:0] KIND_IGNORE = 2'd3;

    localparam logic ACT_START  = 1'b0;
    localparam logic ACT_ANSWER = 1'b1;

    localparam logic [DATA_W-1:0] DIST_MAX = '1;

    typedef struct packed {
        logic       start_load;
        logic       answer;
        logic       sq_mul;
        logic       sq_acc;
        logic       root_init;
        logic       root_step;
        logic       div_init;
        logic       div_step;
        logic       cross_wr;
        logic       side_mul;
        logic       side_wr;
        logic       emit_start;
        logic       emit_miss;
        logic [1:0] axis;
    } t_cmd;

    typedef struct packed {
        logic sum_zero;
        logic reach_zero;
    } t_status;

endpackage

// ----- design/vrt_if.sv -----
// Channel interfaces of the voxel ray traversal core: ray start and
// occupancy answers in, cell queries and outcomes out. No dependencies.
interface vrt_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic [31:0]        reach;
    logic               occupied;

    modport source (output valid, action, origin_x, origin_y, origin_z,
                    dir_x, dir_y, dir_z, reach, occupied, input ready);
    modport sink (input valid, action, origin_x, origin_y, origin_z,
                  dir_x, dir_y, dir_z, reach, occupied, output ready);
endinterface

interface vrt_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic signed [15:0] cell_x;
    logic signed [15:0] cell_y;
    logic signed [15:0] cell_z;
    logic signed [1:0]  face_x;
    logic signed [1:0]  face_y;
    logic signed [1:0]  face_z;
    logic [31:0]        travelled;

    modport source (output valid, kind, cell_x, cell_y, cell_z,
                    face_x, face_y, face_z, travelled, input ready);
    modport sink (input valid, kind, cell_x, cell_y, cell_z,
                  face_x, face_y, face_z, travelled, output ready);
endinterface

// ----- design/voxel_ray_traversal_core.sv -----
// Top level of the voxel ray traversal core: joins controller and datapath
// to the channel interfaces. Depends on vrt_pkg, vrt_if, vrt_ctrl, vrt_dp.
//
//   Channel   Direction   Transaction
//   i_in      in          ray start (action 0) or occupancy answer (action 1)
//   o_out     out         cell query, hit, miss or ignored answer
//
// An answer's result is registered and shown the next cycle.
// A ray start runs the bit-serial square root (32 steps) and three bit-serial
// divides.
// Input is taken only while the controller is idle and the result register is
// empty or being read. Reset is synchronous and clears all control state.
module voxel_ray_traversal_core import vrt_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int CELL_BITS = CELL_BITS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    vrt_in_if.sink    i_in,
    vrt_out_if.source o_out
);

    t_cmd                         cmd;
    t_status                      status;
    logic signed [DATA_W-1:0]     origin [3];
    logic signed [DATA_W-1:0]     dir [3];
    logic signed [OUT_CELL_W-1:0] out_cell [3];
    logic signed [1:0]            face [3];

    assign origin[0] = i_in.origin_x;
    assign origin[1] = i_in.origin_y;
    assign origin[2] = i_in.origin_z;
    assign dir[0]    = i_in.dir_x;
    assign dir[1]    = i_in.dir_y;
    assign dir[2]    = i_in.dir_z;

    vrt_ctrl #(
        .FRAC_BITS(FRAC_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_action    (i_in.action),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    vrt_dp #(
        .FRAC_BITS(FRAC_BITS),
        .CELL_BITS(CELL_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_origin    (origin),
        .i_dir       (dir),
        .i_reach     (i_in.reach),
        .i_occupied  (i_in.occupied),
        .o_status    (status),
        .o_kind      (o_out.kind),
        .o_cell      (out_cell),
        .o_face      (face),
        .o_travelled (o_out.travelled)
    );

    assign o_out.cell_x = out_cell[0];
    assign o_out.cell_y = out_cell[1];
    assign o_out.cell_z = out_cell[2];
    assign o_out.face_x = face[0];
    assign o_out.face_y = face[1];
    assign o_out.face_z = face[2];

endmodule

// ----- design/vrt_ctrl.sv -----
// Controller of the voxel ray traversal core: sequences ray setup (squares,
// root, three divides and side products) and answers. Depends on vrt_pkg.
module vrt_ctrl import vrt_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_action,
    input  logic    i_out_ready,
    input  t_status i_status,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output t_cmd    o_cmd
);

    localparam int DW    = DATA_W + FRAC_BITS;
    localparam int CNT_W = $clog2(DW);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SQ_MUL = 4'd1;
    localparam logic [3:0] S_SQ_ACC = 4'd2;
    localparam logic [3:0] S_ROOT   = 4'd3;
    localparam logic [3:0] S_DINIT  = 4'd4;
    localparam logic [3:0] S_DIV    = 4'd5;
    localparam logic [3:0] S_CRS    = 4'd6;
    localparam logic [3:0] S_SMUL   = 4'd7;
    localparam logic [3:0] S_SWR    = 4'd8;

    logic [3:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [1:0]       r_axis, n_axis;
    logic             r_out_valid, n_out_valid;
    logic             in_acc;
    t_cmd             cmd;

    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_axis   = r_axis;
        cmd      = '0;
        cmd.axis = r_axis;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_action == ACT_START) begin
                        cmd.start_load = 1'b1;
                        n_axis         = 2'd0;
                        n_state        = S_SQ_MUL;
                    end else begin
                        cmd.answer = 1'b1;
                    end
                end
            end
            S_SQ_MUL: begin
                cmd.sq_mul = 1'b1;
                n_state    = S_SQ_ACC;
            end
            S_SQ_ACC: begin
                cmd.sq_acc = 1'b1;
                if (r_axis != 2'd2) begin
                    n_axis  = r_axis + 2'd1;
                    n_state = S_SQ_MUL;
                end else if (i_status.sum_zero || i_status.reach_zero) begin
                    cmd.emit_miss = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    cmd.root_init = 1'b1;
                    n_cnt         = '0;
                    n_state       = S_ROOT;
                end
            end
            S_ROOT: begin
                cmd.root_step = 1'b1;
                if (r_cnt == CNT_W'(DATA_W - 1)) begin
                    n_axis  = 2'd0;
                    n_state = S_DINIT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DINIT: begin
                cmd.div_init = 1'b1;
                n_cnt        = '0;
                n_state      = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (r_cnt == CNT_W'(DW - 1)) begin
                    n_state = S_CRS;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_CRS: begin
                cmd.cross_wr = 1'b1;
                n_state      = S_SMUL;
            end
            S_SMUL: begin
                cmd.side_mul = 1'b1;
                n_state      = S_SWR;
            end
            S_SWR: begin
                cmd.side_wr = 1'b1;
                if (r_axis == 2'd2) begin
                    cmd.emit_start = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    n_axis  = r_axis + 2'd1;
                    n_state = S_DINIT;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.emit_start || cmd.emit_miss || cmd.answer) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_axis      <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_axis      <= n_axis;
            r_out_valid <= n_out_valid;
        end
    end

    a_start_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_action == ACT_START) |=> (r_state == S_SQ_MUL))
        else $error("start transaction did not begin setup");

    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_axis != 2'd3))
        else $error("axis index out of range");

    a_setup_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWR && r_axis == 2'd2) |=> (r_out_valid && r_state == S_IDLE))
        else $error("setup finished without a result");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt <= CNT_W'(DW - 1)))
        else $error("divider step count overran");

endmodule

// ----- design/vrt_dp.sv -----
// Datapath of the voxel ray traversal core: ray state, shared multiplier,
// bitwise root and divider, step logic and result register. Uses vrt_pkg.
module vrt_dp import vrt_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int CELL_BITS = CELL_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cmd                         i_cmd,
    input  logic signed [DATA_W-1:0]     i_origin [3],
    input  logic signed [DATA_W-1:0]     i_dir [3],
    input  logic [DATA_W-1:0]            i_reach,
    input  logic                         i_occupied,
    output t_status                      o_status,
    output logic [1:0]                   o_kind,
    output logic signed [OUT_CELL_W-1:0] o_cell [3],
    output logic signed [1:0]            o_face [3],
    output logic [DATA_W-1:0]            o_travelled
);

    localparam int DW = DATA_W + FRAC_BITS;
    localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

    logic                        r_active;
    logic signed [DATA_W-1:0]    r_org [3];
    logic [DATA_W-1:0]           r_mag [3];
    logic signed [1:0]           r_step [3];
    logic signed [CELL_BITS-1:0] r_cell [3];
    logic [DATA_W-1:0]           r_cross [3];
    logic [DATA_W-1:0]           r_side [3];
    logic signed [1:0]           r_face [3];
    logic [DATA_W-1:0]           r_dist;
    logic [DATA_W-1:0]           r_reach;
    logic [63:0]                 r_sum;
    logic [63:0]                 r_prod;
    logic [63:0]                 r_rootn;
    logic [33:0]                 r_rrem;
    logic [DATA_W-1:0]           r_root;
    logic [DW-1:0]               r_dq;
    logic [DATA_W-1:0]           r_drem;
    logic [1:0]                  r_o_kind;
    logic signed [OUT_CELL_W-1:0] r_o_cell [3];
    logic signed [1:0]           r_o_face [3];
    logic [DATA_W-1:0]           r_o_dist;

    logic [1:0]                  ax;
    logic [FRAC_BITS-1:0]        frac;
    logic [FRAC_BITS:0]          part;
    logic [DATA_W-1:0]           mul_a, mul_b;
    logic [63:0]                 n_sum;
    logic [35:0]                 rt_rem, rt_trial;
    logic                        rt_ge;
    logic [DATA_W:0]             dv_t;
    logic                        dv_ge;
    logic [DATA_W-1:0]           cross_sat;
    logic [1:0]                  sel;
    logic [DATA_W:0]             side_sum;
    logic [DATA_W-1:0]           new_side;
    logic signed [CELL_BITS-1:0] new_cell;
    logic signed [1:0]           new_face;
    logic                        go_on;
    logic signed [DATA_W-1:0]    floor_pos [3];

    function automatic logic signed [OUT_CELL_W-1:0] cell_out(
        input logic signed [CELL_BITS-1:0] c
    );
        logic signed [31:0] ext;
        ext = 32'(c);
        return ext[OUT_CELL_W-1:0];
    endfunction

    assign ax   = i_cmd.axis;
    assign frac = r_org[ax][FRAC_BITS-1:0];
    assign part = (r_step[ax] == 2'sd1) ? (ONE - {1'b0, frac}) : {1'b0, frac};

    assign mul_a = i_cmd.side_mul ? DATA_W'(part) : r_mag[ax];
    assign mul_b = i_cmd.side_mul ? r_cross[ax] : r_mag[ax];

    assign n_sum               = r_sum + r_prod;
    assign o_status.sum_zero   = (n_sum == 64'd0);
    assign o_status.reach_zero = (r_reach == '0);

    assign rt_rem   = {r_rrem, r_rootn[63:62]};
    assign rt_trial = {2'b00, r_root, 2'b01};
    assign rt_ge    = (rt_rem >= rt_trial);

    assign dv_t      = {r_drem, r_dq[DW-1]};
    assign dv_ge     = (dv_t >= {1'b0, r_mag[ax]});
    assign cross_sat = (|r_dq[DW-1:DATA_W]) ? DIST_MAX : r_dq[DATA_W-1:0];

    always_comb begin
        if (r_side[0] < r_side[1]) begin
            sel = (r_side[0] < r_side[2]) ? 2'd0 : 2'd2;
        end else begin
            sel = (r_side[1] < r_side[2]) ? 2'd1 : 2'd2;
        end
    end

    assign side_sum = {1'b0, r_side[sel]} + {1'b0, r_cross[sel]};
    assign new_side = side_sum[DATA_W] ? DIST_MAX : side_sum[DATA_W-1:0];
    assign new_cell = r_cell[sel] + CELL_BITS'(r_step[sel]);
    assign new_face = -r_step[sel];
    assign go_on    = (r_side[sel] < r_reach);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            floor_pos[i] = i_origin[i] >>> FRAC_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_cmd.start_load) begin
            r_active <= 1'b0;
        end else if (i_cmd.emit_start) begin
            r_active <= 1'b1;
        end else if (i_cmd.answer && r_active && (i_occupied || !go_on)) begin
            r_active <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_load) begin
            for (int i = 0; i < 3; i++) begin
                r_org[i]  <= i_origin[i];
                r_mag[i]  <= i_dir[i][DATA_W-1] ? (~i_dir[i] + 1'b1) : i_dir[i];
                r_step[i] <= i_dir[i][DATA_W-1] ? -2'sd1 :
                             ((i_dir[i] == '0) ? 2'sd0 : 2'sd1);
                r_cell[i] <= floor_pos[i][CELL_BITS-1:0];
                r_face[i] <= 2'sd0;
            end
            r_reach <= i_reach;
            r_dist  <= '0;
            r_sum   <= 64'd0;
        end
        if (i_cmd.sq_mul || i_cmd.side_mul) begin
            r_prod <= 64'(mul_a) * 64'(mul_b);
        end
        if (i_cmd.sq_acc) begin
            r_sum <= n_sum;
        end
        if (i_cmd.root_init) begin
            r_rootn <= n_sum;
            r_rrem  <= '0;
            r_root  <= '0;
        end
        if (i_cmd.root_step) begin
            r_rootn <= {r_rootn[61:0], 2'b00};
            r_rrem  <= rt_ge ? 34'(rt_rem - rt_trial) : rt_rem[33:0];
            r_root  <= {r_root[DATA_W-2:0], rt_ge};
        end
        if (i_cmd.div_init) begin
            r_dq   <= {r_root, {FRAC_BITS{1'b0}}};
            r_drem <= '0;
        end
        if (i_cmd.div_step) begin
            r_dq   <= {r_dq[DW-2:0], dv_ge};
            r_drem <= dv_ge ? DATA_W'(dv_t - {1'b0, r_mag[ax]}) : dv_t[DATA_W-1:0];
        end
        if (i_cmd.cross_wr) begin
            r_cross[ax] <= (r_mag[ax] == '0) ? DIST_MAX : cross_sat;
        end
        if (i_cmd.side_wr) begin
            r_side[ax] <= (r_mag[ax] == '0) ? DIST_MAX :
                          r_prod[FRAC_BITS+DATA_W-1:FRAC_BITS];
        end
        if (i_cmd.emit_miss) begin
            r_o_kind <= KIND_MISS;
            r_o_dist <= '0;
            for (int i = 0; i < 3; i++) begin
                r_cell[i]   <= '0;
                r_o_cell[i] <= '0;
                r_o_face[i] <= 2'sd0;
            end
        end
        if (i_cmd.emit_start) begin
            r_o_kind <= KIND_QUERY;
            r_o_dist <= r_dist;
            for (int i = 0; i < 3; i++) begin
                r_o_cell[i] <= cell_out(r_cell[i]);
                r_o_face[i] <= r_face[i];
            end
        end
        if (i_cmd.answer) begin
            if (!r_active) begin
                r_o_kind <= KIND_IGNORE;
                r_o_dist <= '0;
                for (int i = 0; i < 3; i++) begin
                    r_o_cell[i] <= '0;
                    r_o_face[i] <= 2'sd0;
                end
            end else if (i_occupied) begin
                r_o_kind <= KIND_HIT;
                r_o_dist <= r_dist;
                for (int i = 0; i < 3; i++) begin
                    r_o_cell[i] <= cell_out(r_cell[i]);
                    r_o_face[i] <= r_face[i];
                end
            end else begin
                r_dist      <= r_side[sel];
                r_side[sel] <= new_side;
                r_cell[sel] <= new_cell;
                for (int i = 0; i < 3; i++) begin
                    r_face[i] <= (sel == 2'(i)) ? new_face : 2'sd0;
                end
                if (go_on) begin
                    r_o_kind <= KIND_QUERY;
                    r_o_dist <= r_side[sel];
                    for (int i = 0; i < 3; i++) begin
                        r_o_cell[i] <= (sel == 2'(i)) ? cell_out(new_cell)
                                                      : cell_out(r_cell[i]);
                        r_o_face[i] <= (sel == 2'(i)) ? new_face : 2'sd0;
                    end
                end else begin
                    r_o_kind <= KIND_MISS;
                    r_o_dist <= '0;
                    for (int i = 0; i < 3; i++) begin
                        r_o_cell[i] <= '0;
                        r_o_face[i] <= 2'sd0;
                    end
                end
            end
        end
    end

    assign o_kind      = r_o_kind;
    assign o_travelled = r_o_dist;
    assign o_cell      = r_o_cell;
    assign o_face      = r_o_face;

endmodule

// ----- tb/voxel_ray_traversal_checker.sv -----
// Checker for the voxel ray traversal core: watches both channels, predicts
// each result from the accepted transactions and compares it field by field.
// Depends on vrt_pkg and vrt_if.
module voxel_ray_traversal_checker import vrt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    vrt_in_if    i_in,
    vrt_out_if   i_out,
    output int   o_errors,
    output int   o_pending
);

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic signed [15:0] cz;
        logic signed [1:0]  fx;
        logic signed [1:0]  fy;
        logic signed [1:0]  fz;
        logic [31:0]        travel;
    } t_outcome;

    t_outcome           expected_q[$];
    logic               ray_on;
    logic signed [15:0] cell_at[3];
    logic signed [1:0]  dirsign[3];
    logic [31:0]        side[3];
    logic [31:0]        cross_d[3];
    logic [31:0]        dist_at;
    logic signed [1:0]  face[3];
    logic [31:0]        limit;

    function automatic logic [63:0] root64(logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic t_outcome outcome(logic [1:0] kind, bit full);
        t_outcome o;
        o = '0;
        o.kind = kind;
        if (full) begin
            o.cx = cell_at[0]; o.cy = cell_at[1]; o.cz = cell_at[2];
            o.fx = face[0]; o.fy = face[1]; o.fz = face[2];
            o.travel = dist_at;
        end
        return o;
    endfunction

    task automatic trace_ray(input logic [31:0] org[3], input logic [31:0] dir[3],
                             input logic [31:0] reach);
        logic signed [63:0] d;
        logic [63:0] mag[3];
        logic [63:0] sum;
        logic [63:0] len;
        logic [63:0] q;
        logic [63:0] part;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            d = {{32{dir[i][31]}}, dir[i]};
            mag[i] = d < 0 ? -d : d;
            sum += mag[i] * mag[i];
            face[i] = 0;
        end
        ray_on = 0;
        dist_at = 0;
        limit = reach;
        if (sum == 0 || reach == 0) begin
            for (int i = 0; i < 3; i++) cell_at[i] = 0;
            expected_q.push_back(outcome(KIND_MISS, 0));
            return;
        end
        len = root64(sum);
        for (int i = 0; i < 3; i++) begin
            d = {{32{dir[i][31]}}, dir[i]};
            cell_at[i] = org[i][31:16];
            dirsign[i] = d > 0 ? 2'sd1 : (d < 0 ? -2'sd1 : 2'sd0);
            if (mag[i] == 0) begin
                cross_d[i] = DIST_MAX;
                side[i] = DIST_MAX;
            end else begin
                q = (len << 16) / mag[i];
                cross_d[i] = q > 64'hFFFF_FFFF ? DIST_MAX : q[31:0];
                part = d > 0 ? 64'd65536 - org[i][15:0] : {48'd0, org[i][15:0]};
                q = (part * cross_d[i]) >> 16;
                side[i] = q[31:0];
            end
        end
        ray_on = 1;
        expected_q.push_back(outcome(KIND_QUERY, 1));
    endtask

    task automatic step_ray(input logic occ);
        int a;
        logic [32:0] s;
        if (!ray_on) begin
            expected_q.push_back(outcome(KIND_IGNORE, 0));
            return;
        end
        if (occ) begin
            ray_on = 0;
            expected_q.push_back(outcome(KIND_HIT, 1));
            return;
        end
        if (side[0] < side[1]) a = side[0] < side[2] ? 0 : 2;
        else a = side[1] < side[2] ? 1 : 2;
        dist_at = side[a];
        s = side[a] + cross_d[a];
        side[a] = s[32] ? DIST_MAX : s[31:0];
        cell_at[a] = cell_at[a] + dirsign[a];
        for (int i = 0; i < 3; i++) face[i] = 0;
        face[a] = -dirsign[a];
        if (dist_at < limit) begin
            expected_q.push_back(outcome(KIND_QUERY, 1));
        end else begin
            ray_on = 0;
            expected_q.push_back(outcome(KIND_MISS, 0));
        end
    endtask

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        t_outcome got;
        t_outcome want;
        if (!i_rst_n) begin
            ray_on = 0;
            limit = 0;
            dist_at = 0;
            for (int i = 0; i < 3; i++) begin
                cell_at[i] = 0; dirsign[i] = 0; side[i] = 0; cross_d[i] = 0; face[i] = 0;
            end
        end else begin
            if (i_out.valid && i_out.ready) begin
                got = {i_out.kind, i_out.cell_x, i_out.cell_y, i_out.cell_z,
                       i_out.face_x, i_out.face_y, i_out.face_z, i_out.travelled};
                if (expected_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("%0t: result with nothing expected: %p", $realtime, got);
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("%0t: mismatch\n  expected %p\n  actual   %p",
                                     $realtime, want, got);
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                if (i_in.action == ACT_START)
                    trace_ray('{i_in.origin_x, i_in.origin_y, i_in.origin_z},
                              '{i_in.dir_x, i_in.dir_y, i_in.dir_z}, i_in.reach);
                else
                    step_ray(i_in.occupied);
            end
        end
    end

    initial o_errors = 0;

endmodule

// ----- tb/voxel_ray_traversal_core_tb.sv -----
// Testbench top for the voxel ray traversal core: drives rays and occupancy
// answers, applies backpressure and reports the verdict.
// Depends on vrt_pkg, vrt_if, voxel_ray_traversal_core and the checker.
module voxel_ray_traversal_core_tb;
    import vrt_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   errors;
    int   pending;
    bit   calm;
    bit   hold_req;
    bit   held;

    vrt_in_if  in_ch ();
    vrt_out_if out_ch ();

    voxel_ray_traversal_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    voxel_ray_traversal_checker checker_inst (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .i_out     (out_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #6_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        out_ch.ready = 0;
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                out_ch.ready <= 0;
                repeat (600) @(negedge i_clk);
                hold_req = 0;
            end else begin
                out_ch.ready <= calm || $urandom_range(99) >= 19;
                @(negedge i_clk);
            end
        end
    end

    task automatic put(input logic act, input logic [31:0] ox, input logic [31:0] oy,
                       input logic [31:0] oz, input logic [31:0] dx, input logic [31:0] dy,
                       input logic [31:0] dz, input logic [31:0] reach, input logic occ);
        while (!calm && $urandom_range(99) < 19) begin
            in_ch.valid <= 0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1;
        in_ch.action <= act;
        in_ch.origin_x <= ox; in_ch.origin_y <= oy; in_ch.origin_z <= oz;
        in_ch.dir_x <= dx; in_ch.dir_y <= dy; in_ch.dir_z <= dz;
        in_ch.reach <= reach;
        in_ch.occupied <= occ;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic answer(input logic occ);
        put(ACT_ANSWER, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom, occ);
    endtask

    function automatic logic [31:0] rand_dir();
        logic [31:0] m;
        m = {14'd0, 2'($urandom_range(1, 3)), 16'($urandom)};
        case ($urandom_range(9))
            0: return 32'd0;
            1: return $urandom;
            default: return $urandom_range(1) ? m : -m;
        endcase
    endfunction

    function automatic logic [31:0] rand_org();
        if ($urandom_range(3) == 0) return $urandom;
        return {$urandom_range(1) ? 16'hFFF0 + 16'($urandom_range(31)) : 16'($urandom_range(15)),
                16'($urandom)};
    endfunction

    initial begin
        int sent;
        int n;
        in_ch.valid = 0;
        in_ch.action = ACT_START;
        {in_ch.origin_x, in_ch.origin_y, in_ch.origin_z} = '0;
        {in_ch.dir_x, in_ch.dir_y, in_ch.dir_z, in_ch.reach} = '0;
        in_ch.occupied = 0;
        calm = 0;
        hold_req = 0;
        held = 0;
        i_rst_n = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        answer(1'b1);
        put(ACT_START, 0, 0, 0, 0, 0, 0, 32'h0010_0000, 1'b1);
        put(ACT_START, 0, 0, 0, 32'h0001_0000, 0, 0, 0, 1'b0);
        put(ACT_START, 32'h0000_8000, 32'h0000_8000, 0, 32'h0001_0000, 0, 0,
            32'h0004_0000, 1'b0);
        repeat (5) answer(1'b0);
        answer(1'b0);
        put(ACT_START, 32'h7FFF_C000, 32'h8000_0000, 32'h0000_0001, 32'h0001_0000,
            32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_FFFF, 1'b0);
        repeat (3) answer(1'b0);
        put(ACT_START, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000,
            32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
        answer(1'b0);
        answer(1'b1);
        put(ACT_START, 32'h0000_4000, 32'h0000_4000, 32'h0000_4000, 32'h0001_0000,
            32'h0001_0000, 32'h0001_0000, 32'h0008_0000, 1'b0);
        repeat (4) answer(1'b0);
        answer(1'b1);

        sent = 25;
        while (sent < 1800) begin
            if (sent > 600 && sent < 800) calm = 1;
            else calm = 0;
            if (sent > 1000 && !held) begin
                hold_req = 1;
                held = 1;
            end
            put(ACT_START, rand_org(), rand_org(), rand_org(), rand_dir(), rand_dir(),
                rand_dir(), $urandom_range(15) == 0 ? $urandom : $urandom_range(0, 32'h000C_0000),
                1'($urandom_range(1)));
            n = $urandom_range(1, 14);
            for (int k = 0; k < n; k++) answer($urandom_range(11) == 0);
            sent += n + 1;
        end
        calm = 0;
        in_ch.valid <= 0;

        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/vrt_pkg.sv
design/vrt_if.sv
design/vrt_ctrl.sv
design/vrt_dp.sv
design/voxel_ray_traversal_core.sv
tb/voxel_ray_traversal_checker.sv
tb/voxel_ray_traversal_core_tb.sv
